// ===== rtl/core/mbc1_pkg.sv =====
// Shared types, address constants and helper functions for the MBC1 bank mapper.
// Used by the configuration, bank register, decode and top-level modules.
package mbc1_pkg;

  typedef enum logic [2:0] {
    TGT_DROP = 3'd0,
    TGT_ROM  = 3'd1,
    TGT_CRAM = 3'd2,
    TGT_OPEN = 3'd3,
    TGT_SYS  = 3'd4
  } target_t;

  localparam logic [1:0] REG_MAPPER_TYPE = 2'd0;
  localparam logic [1:0] REG_ROM_SIZE    = 2'd1;
  localparam logic [1:0] REG_RAM_SIZE    = 2'd2;

  localparam logic OP_WRITE = 1'b1;

  localparam logic [15:0] ROM_BANKX_LO   = 16'h4000;
  localparam logic [15:0] ROM_END        = 16'h8000;
  localparam logic [15:0] CRAM_LO        = 16'hA000;
  localparam logic [15:0] CRAM_END       = 16'hC000;
  localparam logic [15:0] ECHO_LO        = 16'hE000;
  localparam logic [15:0] ECHO_END       = 16'hFE00;
  localparam logic [15:0] ECHO_OFFSET    = 16'h2000;
  localparam logic [15:0] UNUSABLE_LO    = 16'hFEA0;
  localparam logic [15:0] UNUSABLE_END   = 16'hFEFF;
  localparam logic [15:0] SPEED_REG_ADDR = 16'hFF4D;

  localparam logic [1:0] MBC_RAM_ENABLE = 2'd0;
  localparam logic [1:0] MBC_ROM_BANK   = 2'd1;
  localparam logic [1:0] MBC_UPPER_BANK = 2'd2;
  localparam logic [1:0] MBC_MODE       = 2'd3;

  localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
  localparam logic [3:0] LARGE_ROM_CODE = 4'd4;
  localparam logic [3:0] FULL_MASK_CODE = 4'd7;
  localparam logic [2:0] RAM_FOUR_BANKS = 3'd3;
  localparam logic [2:0] RAM_NONE       = 3'd0;

  typedef struct packed {
    logic [7:0] mapper_type;
    logic [3:0] rom_size_code;
    logic [2:0] ram_size_code;
  } cfg_t;

  typedef struct packed {
    logic       ram_enabled;
    logic [4:0] rom_bank_low;
    logic [1:0] bank_upper;
    logic       banking_mode;
  } bank_t;

  typedef struct packed {
    logic        op;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
  } req_t;

  function automatic logic is_mbc1(input logic [7:0] mapper_type);
    return (mapper_type >= 8'd1) && (mapper_type <= 8'd3);
  endfunction

  function automatic logic [7:0] bank_mask(input logic [3:0] code);
    logic [8:0] full;
    full = (9'd2 << code[2:0]) - 9'd1;
    if (code >= FULL_MASK_CODE) begin
      return 8'hFF;
    end
    return full[7:0];
  endfunction

endpackage

// ===== rtl/core/mbc1_cfg.sv =====
// APB-style register file for the mapper type and the ROM and RAM size codes.
// Depends on mbc1_pkg for the register indexes and the configuration struct.
module mbc1_cfg import mbc1_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_MAPPER_TYPE: cfg.mapper_type   <= pwdata[7:0];
        REG_ROM_SIZE:    cfg.rom_size_code <= pwdata[3:0];
        REG_RAM_SIZE:    cfg.ram_size_code <= pwdata[2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MAPPER_TYPE: prdata = {24'd0, cfg.mapper_type};
      REG_ROM_SIZE:    prdata = {28'd0, cfg.rom_size_code};
      REG_RAM_SIZE:    prdata = {29'd0, cfg.ram_size_code};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/core/mbc1_bank_regs.sv =====
// MBC1 bank registers, updated by bus writes below 0x8000 as each transfer is decoded.
// Depends on mbc1_pkg for the request, configuration and bank structs.
module mbc1_bank_regs import mbc1_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  update,
  input  req_t  req,
  input  cfg_t  cfg,
  output bank_t bank
);

  bank_t bank_next;
  logic  mbc_write;

  assign mbc_write = update && (req.op == OP_WRITE) && (req.bus_address < ROM_END) &&
                     is_mbc1(cfg.mapper_type);

  always_comb begin
    bank_next = bank;
    if (mbc_write) begin
      unique case (req.bus_address[14:13])
        MBC_RAM_ENABLE: bank_next.ram_enabled = (req.write_data[3:0] == RAM_ENABLE_KEY);
        MBC_ROM_BANK: begin
          bank_next.rom_bank_low = (req.write_data[4:0] == 5'd0) ? 5'd1 : req.write_data[4:0];
        end
        MBC_UPPER_BANK: begin
          if ((cfg.rom_size_code > LARGE_ROM_CODE) || (cfg.ram_size_code == RAM_FOUR_BANKS)) begin
            bank_next.bank_upper = req.write_data[1:0];
          end
        end
        MBC_MODE: bank_next.banking_mode = req.write_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank.ram_enabled  <= 1'b0;
      bank.rom_bank_low <= 5'd1;
      bank.bank_upper   <= 2'd0;
      bank.banking_mode <= 1'b0;
    end else begin
      bank <= bank_next;
    end
  end

endmodule

// ===== rtl/core/mbc1_decode.sv =====
// Address decode for one bus transfer: target and physical address from the bank state.
// Depends on mbc1_pkg for constants, structs and the ROM bank mask function.
module mbc1_decode import mbc1_pkg::*; #(
  parameter int ROM_BYTES_LOG2      = 21,
  parameter int CART_RAM_BYTES_LOG2 = 15
) (
  input  req_t        req,
  input  cfg_t        cfg,
  input  bank_t       bank,
  output target_t     target,
  output logic [20:0] mapped_address
);

  logic [7:0]  mask;
  logic [7:0]  low_bank;
  logic [7:0]  high_bank;
  logic [21:0] rom_low_full;
  logic [21:0] rom_high_full;
  logic [20:0] rom_low_addr;
  logic [20:0] rom_high_addr;
  logic [14:0] cram_full;
  logic [20:0] cram_addr;
  logic [15:0] echo_addr;
  logic        mbc;
  logic        cram_on;
  logic        is_write;
  logic [15:0] a;

  always_comb begin
    a        = req.bus_address;
    is_write = (req.op == OP_WRITE);
    mbc      = is_mbc1(cfg.mapper_type);
    mask     = bank_mask(cfg.rom_size_code);

    low_bank      = {1'b0, bank.bank_upper, 5'd0} & mask;
    high_bank     = {1'b0, bank.bank_upper, bank.rom_bank_low} & mask;
    rom_low_full  = {low_bank, a[13:0]};
    rom_high_full = {high_bank, a[13:0]};
    rom_low_addr  = '0;
    rom_high_addr = '0;
    rom_low_addr[ROM_BYTES_LOG2-1:0]  = rom_low_full[ROM_BYTES_LOG2-1:0];
    rom_high_addr[ROM_BYTES_LOG2-1:0] = rom_high_full[ROM_BYTES_LOG2-1:0];

    cram_on   = mbc && bank.ram_enabled && (cfg.ram_size_code != RAM_NONE);
    cram_full = {2'd0, a[12:0]};
    if ((cfg.ram_size_code >= RAM_FOUR_BANKS) && bank.banking_mode) begin
      cram_full = {bank.bank_upper, a[12:0]};
    end
    cram_addr = '0;
    cram_addr[CART_RAM_BYTES_LOG2-1:0] = cram_full[CART_RAM_BYTES_LOG2-1:0];

    echo_addr = a - ECHO_OFFSET;

    target         = TGT_SYS;
    mapped_address = {5'd0, a};

    if (is_write) begin
      priority if (a < ROM_END) begin
        target         = TGT_DROP;
        mapped_address = '0;
      end else if ((a >= CRAM_LO) && (a < CRAM_END)) begin
        target         = cram_on ? TGT_CRAM : TGT_DROP;
        mapped_address = cram_on ? cram_addr : 21'd0;
      end else if ((a >= ECHO_LO) && (a < ECHO_END)) begin
        mapped_address = {5'd0, echo_addr};
      end else if ((a >= UNUSABLE_LO) && (a < UNUSABLE_END)) begin
        target         = TGT_DROP;
        mapped_address = '0;
      end else begin
      end
    end else begin
      priority if ((a >= ECHO_LO) && (a < ECHO_END)) begin
        mapped_address = {5'd0, echo_addr};
      end else if (a == SPEED_REG_ADDR) begin
        target         = TGT_OPEN;
        mapped_address = '0;
      end else if (a < ROM_BANKX_LO) begin
        if (mbc && bank.banking_mode && (cfg.rom_size_code > LARGE_ROM_CODE)) begin
          target         = TGT_ROM;
          mapped_address = rom_low_addr;
        end
      end else if (a < ROM_END) begin
        if (mbc) begin
          target         = TGT_ROM;
          mapped_address = rom_high_addr;
        end
      end else if ((a >= CRAM_LO) && (a < CRAM_END)) begin
        target         = cram_on ? TGT_CRAM : TGT_OPEN;
        mapped_address = cram_on ? cram_addr : 21'd0;
      end else begin
      end
    end
  end

endmodule

// ===== rtl/core/mbc1_bank_mapper.sv =====
// MBC1 bank mapper top level: input register, decode, bank registers and result register.
// Depends on mbc1_pkg, mbc1_cfg, mbc1_bank_regs and mbc1_decode.
//
// Usage: the CPU side presents one bus access (op, bus_address, write_data) with
// in_valid; a transfer happens at a clock edge where in_valid is high and in_stall
// is low. Each access yields exactly one result (target, mapped_address) on the
// output channel, transferred where out_valid is high and out_stall is low.
// The access is held in an input register and decoded from there into the result
// register. One access can be taken every cycle while the receiver does not stall;
// the bank registers are updated as each write is decoded, so the following access
// already sees the new banks. When the receiver stalls, the result register holds,
// the input register fills, and in_stall rises until the result is taken. Reset
// clears both stages, the configuration registers and the bank registers (ROM bank
// low comes up as one).
// The configuration registers are to be written through the APB-style port only
// while no access is in flight; the block itself does not enforce this.
module mbc1_bank_mapper import mbc1_pkg::*; #(
  parameter int ROM_BYTES_LOG2      = 21,
  parameter int CART_RAM_BYTES_LOG2 = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [15:0] bus_address,
  input  logic [7:0]  write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  target,
  output logic [20:0] mapped_address
);

  cfg_t        cfg;
  bank_t       bank;
  req_t        in_q;
  logic        in_q_valid;
  logic        advance;
  target_t     dec_target;
  logic [20:0] dec_address;
  target_t     out_target;
  logic [20:0] out_address;

  assign advance  = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !advance;

  mbc1_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mbc1_bank_regs u_bank_regs (
    .clk    (clk),
    .rst    (rst),
    .update (advance),
    .req    (in_q),
    .cfg    (cfg),
    .bank   (bank)
  );

  mbc1_decode #(
    .ROM_BYTES_LOG2      (ROM_BYTES_LOG2),
    .CART_RAM_BYTES_LOG2 (CART_RAM_BYTES_LOG2)
  ) u_decode (
    .req            (in_q),
    .cfg            (cfg),
    .bank           (bank),
    .target         (dec_target),
    .mapped_address (dec_address)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q.op          <= op;
      in_q.bus_address <= bus_address;
      in_q.write_data  <= write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_target  <= dec_target;
      out_address <= dec_address;
    end
  end

  assign target         = out_target;
  assign mapped_address = out_address;

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the result register can drain");

  a_no_address_when_unmapped: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ((target == TGT_DROP) || (target == TGT_OPEN))) |-> (mapped_address == 21'd0))
    else $error("dropped or open-bus result carries an address");

  a_rom_bank_nonzero: assert property (@(posedge clk) disable iff (rst)
    bank.rom_bank_low != 5'd0)
    else $error("low ROM bank register holds zero");

  a_decoded_item_presented: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("decoded transfer did not reach the result register");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for mbc1_bank_mapper: directed accesses, then random bus traffic
// under several cartridge settings, each result checked against a predictor of the bank logic.
// Depends on mbc1_pkg and the mbc1_bank_mapper RTL.
module tb import mbc1_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_READ      = ~OP_WRITE;
  localparam int   IDLE_LIMIT   = 2000;
  localparam int   DRAIN_CYCLES = 4;
  localparam int   SEGMENTS     = 13;
  localparam int   SEG_ITEMS    = 50;

  typedef struct packed {
    target_t     tgt;
    logic [20:0] maddr;
  } landing_t;

  typedef struct packed {
    bit          is_cfg;
    bit          typed;
    logic        op;
    logic [15:0] addr;
    logic [7:0]  data;
    landing_t    want;
  } step_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic        op;
  logic [15:0] bus_address;
  logic [7:0]  write_data;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  target;
  logic [20:0] mapped_address;

  logic [7:0] cfg_mapper   = 8'd0;
  logic [3:0] cfg_rom_code = 4'd0;
  logic [2:0] cfg_ram_code = 3'd0;
  logic       ram_on       = 1'b0;
  logic [4:0] rom_low      = 5'd1;
  logic [1:0] upper_bank   = 2'd0;
  logic       bank_mode    = 1'b0;

  landing_t landing_q[$];
  landing_t due;
  int       mismatches   = 0;
  int       quiet_cycles = 0;
  int       send_pct     = 0;
  int       recv_pct     = 0;

  logic [7:0] fixed_mapper [5] = '{8'd1, 8'd255, 8'd3, 8'd2, 8'd0};
  logic [3:0] fixed_rom    [5] = '{4'd8, 4'd0, 4'd4, 4'd5, 4'd8};
  logic [2:0] fixed_ram    [5] = '{3'd3, 3'd0, 3'd5, 3'd2, 3'd5};

  mbc1_bank_mapper u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .bus_address(bus_address), .write_data(write_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .target(target), .mapped_address(mapped_address)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic landing_t cram_landing(input logic is_write, input logic [15:0] a);
    landing_t   r;
    logic [15:0] off;
    off = a - CRAM_LO;
    r.maddr = 21'd0;
    r.tgt = is_write ? TGT_DROP : TGT_OPEN;
    if ((cfg_mapper >= 8'd1) && (cfg_mapper <= 8'd3) && ram_on && (cfg_ram_code != RAM_NONE))
    begin
      if (cfg_ram_code >= RAM_FOUR_BANKS && bank_mode) begin
        off = off + {1'b0, upper_bank, 13'd0};
      end
      r.tgt = TGT_CRAM;
      r.maddr = 21'(off[14:0]);
    end
    return r;
  endfunction

  function automatic landing_t map_access(input logic o, input logic [15:0] a,
                                          input logic [7:0] d);
    landing_t   r;
    logic       mbc;
    logic [7:0] mask;
    logic [7:0] bank;
    mbc = (cfg_mapper >= 8'd1) && (cfg_mapper <= 8'd3);
    mask = (cfg_rom_code >= 4'd7) ? 8'hFF : 8'((16'd2 << cfg_rom_code) - 16'd1);
    r.tgt = TGT_SYS;
    r.maddr = 21'(a);
    if (o == OP_WRITE) begin
      if (a < ROM_END) begin
        if (mbc) begin
          case (a[14:13])
            MBC_RAM_ENABLE: ram_on = (d[3:0] == RAM_ENABLE_KEY);
            MBC_ROM_BANK: rom_low = (d[4:0] == 5'd0) ? 5'd1 : d[4:0];
            MBC_UPPER_BANK: begin
              if (cfg_rom_code > LARGE_ROM_CODE || cfg_ram_code == RAM_FOUR_BANKS) begin
                upper_bank = d[1:0];
              end
            end
            default: bank_mode = d[0];
          endcase
        end
        r.tgt = TGT_DROP;
        r.maddr = 21'd0;
      end else if (a >= CRAM_LO && a < CRAM_END) begin
        r = cram_landing(1'b1, a);
      end else if (a >= ECHO_LO && a < ECHO_END) begin
        r.maddr = 21'(a - ECHO_OFFSET);
      end else if (a >= UNUSABLE_LO && a < UNUSABLE_END) begin
        r.tgt = TGT_DROP;
        r.maddr = 21'd0;
      end
    end else begin
      if (a >= ECHO_LO && a < ECHO_END) begin
        r.maddr = 21'(a - ECHO_OFFSET);
      end else if (a == SPEED_REG_ADDR) begin
        r.tgt = TGT_OPEN;
        r.maddr = 21'd0;
      end else if (a < ROM_BANKX_LO) begin
        if (mbc && bank_mode && cfg_rom_code > LARGE_ROM_CODE) begin
          bank = {1'b0, upper_bank, 5'd0} & mask;
          r.tgt = TGT_ROM;
          r.maddr = 21'({bank, 14'd0} + a);
        end
      end else if (a < ROM_END) begin
        if (mbc) begin
          bank = {1'b0, upper_bank, rom_low} & mask;
          r.tgt = TGT_ROM;
          r.maddr = 21'({bank, 14'd0} + (a - ROM_BANKX_LO));
        end
      end else if (a >= CRAM_LO && a < CRAM_END) begin
        r = cram_landing(1'b0, a);
      end
    end
    return r;
  endfunction

  function automatic step_t access_row(input logic o, input logic [15:0] a,
                                       input logic [7:0] d);
    step_t s;
    s = '0;
    s.op = o;
    s.addr = a;
    s.data = d;
    return s;
  endfunction

  function automatic step_t checked_row(input logic o, input logic [15:0] a,
                                        input logic [7:0] d, input target_t t,
                                        input logic [20:0] m);
    step_t s;
    s = access_row(o, a, d);
    s.typed = 1'b1;
    s.want.tgt = t;
    s.want.maddr = m;
    return s;
  endfunction

  function automatic step_t config_row(input logic [1:0] idx, input logic [7:0] v);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.addr = 16'(idx);
    s.data = v;
    return s;
  endfunction

  task automatic send_access(input logic o, input logic [15:0] a, input logic [7:0] d,
                             input bit typed, input landing_t want);
    landing_t pred;
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    bus_address <= a;
    write_data <= d;
    do @(posedge clk); while (in_stall);
    pred = map_access(o, a, d);
    landing_q.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (landing_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_config(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata != value) begin
      $display("%0t: register %0d expected %0h got %0h", $time, idx, value, prdata);
      mismatches++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_MAPPER_TYPE: cfg_mapper = value[7:0];
      REG_ROM_SIZE: cfg_rom_code = value[3:0];
      REG_RAM_SIZE: cfg_ram_code = value[2:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic random_access(output logic o, output logic [15:0] a, output logic [7:0] d);
    int sel;
    sel = $urandom_range(99);
    o = logic'($urandom_range(1));
    d = 8'($urandom_range(255));
    if (sel < 30) begin
      o = OP_WRITE;
      a = 16'($urandom_range(16'h7FFF));
      if (a[14:13] == MBC_RAM_ENABLE && $urandom_range(1) == 1) begin
        d[3:0] = RAM_ENABLE_KEY;
      end
      if (a[14:13] == MBC_ROM_BANK && $urandom_range(3) == 0) begin
        d[4:0] = 5'd0;
      end
    end else if (sel < 55) begin
      o = OP_READ;
      a = 16'($urandom_range(16'h7FFF));
    end else if (sel < 75) begin
      a = 16'($urandom_range(16'hBFFF, 16'hA000));
    end else if (sel < 83) begin
      a = 16'($urandom_range(16'hFDFF, 16'hE000));
    end else if (sel < 90) begin
      a = ($urandom_range(3) == 0) ? SPEED_REG_ADDR : 16'($urandom_range(16'hFFFF, 16'hFE00));
    end else begin
      a = 16'($urandom_range(16'hFFFF));
    end
  endtask

  always @(negedge clk) begin
    out_stall <= (recv_pct != 0) && ($urandom_range(99) < recv_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (landing_q.size() == 0) begin
        $display("%0t: unexpected result target %0d address %0h", $time, target,
                 mapped_address);
        mismatches++;
      end else begin
        due = landing_q.pop_front();
        if (target != due.tgt) begin
          $display("%0t: target expected %0d got %0d", $time, due.tgt, target);
          mismatches++;
        end
        if (mapped_address != due.maddr) begin
          $display("%0t: mapped_address expected %0h got %0h", $time, due.maddr,
                   mapped_address);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    step_t       plan[$];
    logic        o;
    logic [15:0] a;
    logic [7:0]  d;
    logic [7:0]  m_val;
    logic [3:0]  rom_val;
    logic [2:0]  ram_val;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    op = 1'b0;
    bus_address = '0;
    write_data = '0;

    // Plain cartridge after reset: no banking, fixed decode of the upper map.
    plan.push_back(checked_row(OP_READ, 16'h0000, 8'h00, TGT_SYS, 21'h00000));
    plan.push_back(checked_row(OP_READ, 16'h7FFF, 8'hFF, TGT_SYS, 21'h07FFF));
    plan.push_back(checked_row(OP_WRITE, 16'h2000, 8'h00, TGT_DROP, 21'h0));
    plan.push_back(checked_row(OP_READ, 16'hA000, 8'h00, TGT_OPEN, 21'h0));
    plan.push_back(checked_row(OP_WRITE, 16'hBFFF, 8'hFF, TGT_DROP, 21'h0));
    plan.push_back(checked_row(OP_READ, SPEED_REG_ADDR, 8'h00, TGT_OPEN, 21'h0));
    plan.push_back(checked_row(OP_WRITE, SPEED_REG_ADDR, 8'h55, TGT_SYS, 21'h0FF4D));
    plan.push_back(checked_row(OP_READ, 16'hE000, 8'h00, TGT_SYS, 21'h0C000));
    plan.push_back(checked_row(OP_WRITE, 16'hFDFF, 8'hAA, TGT_SYS, 21'h0DDFF));
    plan.push_back(checked_row(OP_WRITE, 16'hFEA0, 8'h01, TGT_DROP, 21'h0));
    plan.push_back(checked_row(OP_WRITE, 16'hFEFE, 8'h02, TGT_DROP, 21'h0));
    plan.push_back(checked_row(OP_WRITE, 16'hFEFF, 8'h03, TGT_SYS, 21'h0FEFF));
    plan.push_back(checked_row(OP_READ, 16'hFEA0, 8'h00, TGT_SYS, 21'h0FEA0));
    plan.push_back(checked_row(OP_WRITE, 16'hFFFF, 8'hFF, TGT_SYS, 21'h0FFFF));
    // Largest ROM with four RAM banks.
    plan.push_back(config_row(REG_MAPPER_TYPE, 8'd1));
    plan.push_back(config_row(REG_ROM_SIZE, 8'd8));
    plan.push_back(config_row(REG_RAM_SIZE, 8'd3));
    plan.push_back(checked_row(OP_READ, 16'h4000, 8'h00, TGT_ROM, 21'h04000));
    plan.push_back(checked_row(OP_WRITE, 16'h0000, 8'h0A, TGT_DROP, 21'h0));
    plan.push_back(checked_row(OP_WRITE, 16'h2000, 8'h00, TGT_DROP, 21'h0));
    plan.push_back(access_row(OP_READ, 16'h7FFF, 8'h00));
    plan.push_back(checked_row(OP_WRITE, 16'h3FFF, 8'hFF, TGT_DROP, 21'h0));
    plan.push_back(checked_row(OP_WRITE, 16'h4000, 8'hFF, TGT_DROP, 21'h0));
    plan.push_back(checked_row(OP_WRITE, 16'h7FFF, 8'hFF, TGT_DROP, 21'h0));
    plan.push_back(access_row(OP_READ, 16'h0000, 8'h00));
    plan.push_back(checked_row(OP_READ, 16'h7FFF, 8'h00, TGT_ROM, 21'h1FFFFF));
    plan.push_back(access_row(OP_READ, 16'hA000, 8'h00));
    plan.push_back(access_row(OP_WRITE, 16'hBFFF, 8'h5A));
    plan.push_back(checked_row(OP_WRITE, 16'h1FFF, 8'h0B, TGT_DROP, 21'h0));
    plan.push_back(checked_row(OP_READ, 16'hBFFF, 8'h00, TGT_OPEN, 21'h0));

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_pct = 27;
    recv_pct = 54;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_config(plan[i].addr[1:0], 32'(plan[i].data));
      end else begin
        send_access(plan[i].op, plan[i].addr, plan[i].data, plan[i].typed, plan[i].want);
      end
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      if (seg < 5) begin
        send_pct = 27;
        recv_pct = 54;
        m_val = fixed_mapper[seg];
        rom_val = fixed_rom[seg];
        ram_val = fixed_ram[seg];
      end else begin
        if (seg < 9) begin
          send_pct = 54;
          recv_pct = 27;
        end else begin
          send_pct = 0;
          recv_pct = 0;
        end
        m_val = ($urandom_range(9) < 7) ? 8'($urandom_range(3, 1)) : 8'($urandom_range(255));
        rom_val = 4'($urandom_range(8));
        ram_val = 3'($urandom_range(5));
      end
      write_config(REG_MAPPER_TYPE, 32'(m_val));
      write_config(REG_ROM_SIZE, 32'(rom_val));
      write_config(REG_RAM_SIZE, 32'(ram_val));
      repeat (SEG_ITEMS) begin
        random_access(o, a, d);
        send_access(o, a, d, 1'b0, '0);
      end
    end

    settle();
    if (mismatches == 0 && landing_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== mbc1_bank_mapper.f =====
rtl/core/mbc1_pkg.sv
rtl/core/mbc1_cfg.sv
rtl/core/mbc1_bank_regs.sv
rtl/core/mbc1_decode.sv
rtl/core/mbc1_bank_mapper.sv
tb/tb.sv
